// File: design/mct_pkg.sv
package mct_pkg;

    localparam int MaxWorkers = 8;
    localparam int WorkerBits = 3;
    localparam int Kinds = 4;
    localparam int TimeBits = 32;
    localparam int LenBits = 24;
    localparam int RecBits = 3 * TimeBits;

    localparam logic [0:0] CfgWorkerCount = 1'b0;
    localparam logic [0:0] CfgKindMap = 1'b1;

    localparam logic OpPush = 1'b0;
    localparam logic OpPop = 1'b1;

    typedef struct packed {
        logic op;
        logic [31:0] now;
        logic [3:0] kind_mask;
        logic [3:0] unknown_mask;
        logic [23:0] length_kind0;
        logic [23:0] length_kind1;
        logic [23:0] length_kind2;
        logic [23:0] length_kind3;
        logic high_priority;
        logic [2:0] pop_worker;
        logic [23:0] pop_length;
    } t_in;

    typedef struct packed {
        logic [2:0] chosen_worker;
        logic [23:0] assigned_length;
        logic to_front;
        logic no_worker;
        logic [31:0] worker_end_time;
    } t_out;

    typedef struct packed {
        logic [TimeBits-1:0] start_t;
        logic [TimeBits-1:0] end_t;
        logic [TimeBits-1:0] queued;
    } t_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_POP,
        ST_COMMIT,
        ST_OUT
    } t_state;

    function automatic logic [TimeBits-1:0] sat_add(
        input logic [TimeBits-1:0] a,
        input logic [TimeBits-1:0] b
    );
        logic [TimeBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[TimeBits] ? '1 : s[TimeBits-1:0];
    endfunction

endpackage

// File: design/mct_ram.sv
module mct_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/min_completion_time_worker_select_unit.sv
// Minimum-completion-time worker selector. Per-worker start, end and queued
// length live in one RAM with a registered read. A push walks the active
// workers one per cycle (read, clamp to now, compare, write back), stopping
// early at a worker whose kind is marked unknown, then charges the winner.
// A pop is a read-modify-write of one entry. One transaction is in flight at
// a time; the result sits in an output register. After reset a clearing
// pass zeroes the RAM before the first item is taken.
module min_completion_time_worker_select_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mct_pkg::t_in       i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mct_pkg::t_out      o_data,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int WB = mct_pkg::WorkerBits;
    localparam int TB = mct_pkg::TimeBits;

    mct_pkg::t_state r_state, n_state;
    logic [3:0] r_count;
    logic [15:0] r_kmap;
    mct_pkg::t_in r_in;
    mct_pkg::t_out r_out, n_out;
    logic r_ovalid, n_ovalid;
    logic r_clr, n_clr;
    logic [WB:0] r_idx, n_idx;
    logic r_found, n_found;
    logic [WB-1:0] r_best, n_best;
    logic [TB-1:0] r_best_end, n_best_end;
    logic [23:0] r_model, n_model;

    logic we;
    logic [WB-1:0] waddr, raddr;
    mct_pkg::t_rec wdata, rdata;

    mct_ram #(.Width(mct_pkg::RecBits), .Depth(mct_pkg::MaxWorkers)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [3:0] cnt_eff;
    assign cnt_eff = (r_count > 4'd8) ? 4'd8 : r_count;

    logic [WB-1:0] cur;
    logic [1:0] kd;
    logic [23:0] klen;
    logic [TB-1:0] cs, ce, cand;
    assign cur = r_idx[WB-1:0];
    assign kd = r_kmap[2*cur +: 2];
    always_comb begin
        case (kd)
            2'd0: klen = r_in.length_kind0;
            2'd1: klen = r_in.length_kind1;
            2'd2: klen = r_in.length_kind2;
            default: klen = r_in.length_kind3;
        endcase
    end
    assign cs = (rdata.start_t > r_in.now) ? rdata.start_t : r_in.now;
    assign ce = (rdata.end_t > r_in.now) ? rdata.end_t : r_in.now;
    assign cand = mct_pkg::sat_add(mct_pkg::sat_add(cs, rdata.queued),
        {{(TB-24){1'b0}}, klen});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mct_pkg::ST_IDLE;
            r_count <= 4'd1;
            r_kmap <= '0;
            r_ovalid <= 1'b0;
            r_clr <= 1'b1;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_clr <= n_clr;
            r_idx <= n_idx;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mct_pkg::CfgWorkerCount: r_count <= i_cfg_data[3:0];
                    mct_pkg::CfgKindMap: r_kmap <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        if (o_ready && i_valid) r_in <= i_data;
        r_out <= n_out;
        r_found <= n_found;
        r_best <= n_best;
        r_best_end <= n_best_end;
        r_model <= n_model;
    end

    assign o_ready = (r_state == mct_pkg::ST_IDLE) && !r_clr;
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_comb begin
        logic [TB-1:0] q, st;
        n_state = r_state;
        n_out = r_out;
        n_ovalid = r_ovalid;
        n_clr = r_clr;
        n_idx = r_idx;
        n_found = r_found;
        n_best = r_best;
        n_best_end = r_best_end;
        n_model = r_model;
        we = 1'b0;
        waddr = cur;
        wdata = '0;
        raddr = cur;
        q = '0;
        st = '0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            mct_pkg::ST_IDLE: begin
                if (r_clr) begin
                    we = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == (WB+1)'(mct_pkg::MaxWorkers - 1)) begin
                        n_clr = 1'b0;
                        n_idx = '0;
                    end
                end else if (i_valid) begin
                    n_found = 1'b0;
                    n_idx = '0;
                    if (i_data.op == mct_pkg::OpPop) begin
                        n_state = mct_pkg::ST_POP;
                        raddr = i_data.pop_worker;
                        n_idx = {1'b0, i_data.pop_worker};
                    end else if (cnt_eff == 4'd0) begin
                        n_state = mct_pkg::ST_COMMIT;
                    end else begin
                        n_state = mct_pkg::ST_SCAN;
                        raddr = '0;
                    end
                end
            end
            mct_pkg::ST_SCAN: begin
                we = 1'b1;
                wdata.start_t = cs;
                wdata.end_t = ce;
                wdata.queued = rdata.queued;
                n_idx = r_idx + 1'b1;
                raddr = n_idx[WB-1:0];
                n_state = ({1'b0, n_idx} == {1'b0, cnt_eff}) ? mct_pkg::ST_READ
                                                              : mct_pkg::ST_SCAN;
                if (r_in.kind_mask[kd]) begin
                    if (r_in.unknown_mask[kd]) begin
                        n_found = 1'b1;
                        n_best = cur;
                        n_model = '0;
                        n_state = mct_pkg::ST_READ;
                    end else if (!r_found || cand < r_best_end) begin
                        n_found = 1'b1;
                        n_best = cur;
                        n_best_end = cand;
                        n_model = klen;
                    end
                end
                if (n_state == mct_pkg::ST_READ) raddr = n_best;
            end
            mct_pkg::ST_READ: begin
                raddr = r_best;
                n_state = mct_pkg::ST_COMMIT;
            end
            mct_pkg::ST_COMMIT: begin
                n_out = '0;
                n_out.no_worker = 1'b1;
                if (r_found) begin
                    waddr = r_best;
                    we = 1'b1;
                    wdata = rdata;
                    wdata.end_t = mct_pkg::sat_add(rdata.end_t, {8'd0, r_model});
                    wdata.queued = mct_pkg::sat_add(rdata.queued, {8'd0, r_model});
                    n_out.chosen_worker = r_best;
                    n_out.assigned_length = r_model;
                    n_out.to_front = r_in.high_priority;
                    n_out.no_worker = 1'b0;
                    n_out.worker_end_time = wdata.end_t;
                end
                n_state = mct_pkg::ST_OUT;
                n_ovalid = 1'b1;
            end
            mct_pkg::ST_POP: begin
                we = 1'b1;
                q = (rdata.queued > {8'd0, r_in.pop_length})
                    ? rdata.queued - {8'd0, r_in.pop_length} : '0;
                st = mct_pkg::sat_add(r_in.now, {8'd0, r_in.pop_length});
                wdata.queued = q;
                wdata.start_t = st;
                wdata.end_t = mct_pkg::sat_add(st, q);
                n_out.chosen_worker = r_in.pop_worker;
                n_out.assigned_length = r_in.pop_length;
                n_out.to_front = 1'b0;
                n_out.no_worker = 1'b0;
                n_out.worker_end_time = wdata.end_t;
                n_ovalid = 1'b1;
                n_state = mct_pkg::ST_OUT;
            end
            mct_pkg::ST_OUT: begin
                if (!r_ovalid || i_ready) n_state = mct_pkg::ST_IDLE;
            end
            default: n_state = mct_pkg::ST_IDLE;
        endcase
    end
endmodule

// File: design/mct_checker.sv
module mct_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input mct_pkg::t_out o_data
);
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("out changed");
    a_nw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.no_worker |-> o_data.assigned_length == 0 &&
        o_data.worker_end_time == 0) else $error("no_worker payload");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid |=> !o_ready) else $error("accepted twice");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind min_completion_time_worker_select_unit mct_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
